// ===== hw/rtl/ba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ba_pkg
// Shared codes and types of the buddy allocator.
// ----------------------------------------------------------------------------
package ba_pkg;

  // defaults of the top level parameters
  localparam int TOTAL_UNITS_DEF = 1024;
  localparam int ID_BITS_DEF     = 16;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // node states held in the tree memory
  localparam logic [1:0] NS_ABSENT = 2'd0;
  localparam logic [1:0] NS_FREE   = 2'd1;
  localparam logic [1:0] NS_ALLOC  = 2'd2;
  localparam logic [1:0] NS_SPLIT  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_FREED     = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_NO_BLOCK  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // request word
  typedef struct packed {
    logic        req_type;
    logic [15:0] proc_id;
    logic [15:0] size_kb;
  } req_t;

  // result word
  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  block_addr;
    logic [10:0] block_size;
  } res_t;

endpackage

// ===== hw/rtl/buddy_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_allocator
// Buddy allocator over a pool of TOTAL_UNITS units kept as a block tree.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one word per request: tuser holds the
// request kind (allocate or free), tdata the owner id and the size in units.
// Each request gives exactly one result word on the m_axis channel: tuser is
// the status, tdata the start unit and size of the block (zero on failure).
// The tree of node states and the owner tags sit in two memories with one
// write and one read port and registered read data; every node visit is a
// read and a check. An allocate scans the free candidates from the fitting
// level up, up to about 2*TOTAL_UNITS node visits, then at each split marks
// the block split and both halves free. A free visits all 2*TOTAL_UNITS-1
// nodes, then at each merge level reads and checks the buddy and writes the
// pair absent and the parent free. One request is in work at a time.
// After reset the node memory is swept once while s_axis_tready stays low.
// A result waits in an output register while the receiver stalls; the next
// request may be accepted and worked meanwhile, and it holds its result
// until the register empties.
// ----------------------------------------------------------------------------
module buddy_allocator #(
  parameter int TOTAL_UNITS = ba_pkg::TOTAL_UNITS_DEF,
  parameter int ID_BITS     = ba_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // proc_id, size_kb
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // block_addr, block_size, zero pad
  output logic [2:0]  m_axis_tuser   // status
);
  import ba_pkg::*;

  req_t req;
  res_t res;
  logic res_valid;
  logic res_ready;

  // unpack request word
  assign req = '{req_type: s_axis_tuser, proc_id: s_axis_tdata[15:0],
                 size_kb: s_axis_tdata[31:16]};

  ba_ctrl #(.TOTAL_UNITS(TOTAL_UNITS), .ID_BITS(ID_BITS)) u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(s_axis_tvalid), .req_ready(s_axis_tready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tuser <= res.status;
      m_axis_tdata <= {3'd0, res.block_size, res.block_addr};
    end
  end

endmodule

// ===== hw/rtl/ba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ba_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module ba_ram #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ba_ctrl
// Sequencer that searches, splits and merges the block tree held in memory.
// ----------------------------------------------------------------------------
module ba_ctrl #(
  parameter int TOTAL_UNITS = ba_pkg::TOTAL_UNITS_DEF,
  parameter int ID_BITS     = ba_pkg::ID_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ba_pkg::req_t  req,
  output logic          res_valid,
  input  logic          res_ready,
  output ba_pkg::res_t  res
);
  import ba_pkg::*;

  localparam int LW    = $clog2(TOTAL_UNITS);
  localparam int NW    = LW + 1;
  localparam int DW    = $clog2(LW + 1);
  localparam int NODES = 2 * TOTAL_UNITS - 1;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_A_RD  = 5'd2;
  localparam logic [4:0] S_A_CHK = 5'd3;
  localparam logic [4:0] S_SP0   = 5'd4;
  localparam logic [4:0] S_SP1   = 5'd5;
  localparam logic [4:0] S_SP2   = 5'd6;
  localparam logic [4:0] S_MARK  = 5'd7;
  localparam logic [4:0] S_F_RD  = 5'd8;
  localparam logic [4:0] S_F_CHK = 5'd9;
  localparam logic [4:0] S_F_SET = 5'd10;
  localparam logic [4:0] S_M_RD  = 5'd11;
  localparam logic [4:0] S_M_CHK = 5'd12;
  localparam logic [4:0] S_M_W0  = 5'd13;
  localparam logic [4:0] S_M_W1  = 5'd14;
  localparam logic [4:0] S_M_W2  = 5'd15;
  localparam logic [4:0] S_RESP  = 5'd16;

  function automatic logic [NW-1:0] node_of(logic [DW-1:0] dd, logic [LW-1:0] kk);
    logic [NW-1:0] b;
    b = (NW'(1) << dd) - NW'(1);
    return b + NW'(kk);
  endfunction

  function automatic logic [LW-1:0] start_of(logic [DW-1:0] dd, logic [LW-1:0] kk);
    return kk << (DW'(LW) - dd);
  endfunction

  function automatic logic [NW-1:0] size_of(logic [DW-1:0] dd);
    return (NW'(1) << LW) >> dd;
  endfunction

  function automatic logic [LW-1:0] kmax_of(logic [DW-1:0] dd);
    logic [NW-1:0] t;
    t = (NW'(1) << dd) - NW'(1);
    return t[LW-1:0];
  endfunction

  logic [4:0]         state;
  logic [4:0]         state_next;
  logic [NW-1:0]      clr;
  logic [DW-1:0]      d;
  logic [LW-1:0]      k;
  logic [DW-1:0]      lvl;
  logic [ID_BITS-1:0] id;
  logic               found;
  logic [DW-1:0]      best_d;
  logic [LW-1:0]      best_k;
  logic [LW-1:0]      best_start;

  logic               ns_we;
  logic [NW-1:0]      ns_waddr;
  logic [1:0]         ns_wdata;
  logic [NW-1:0]      ns_raddr;
  logic [1:0]         ns_rdata;
  logic               tag_we;
  logic [ID_BITS-1:0] tag_rdata;

  // tree node states and owner tags
  ba_ram #(.DEPTH(NODES), .AW(NW), .WIDTH(2)) u_node_mem (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
    .raddr(ns_raddr), .rdata(ns_rdata)
  );

  ba_ram #(.DEPTH(TOTAL_UNITS), .AW(LW), .WIDTH(ID_BITS)) u_tag_mem (
    .clk(clk), .we(tag_we), .waddr(start_of(d, k)), .wdata(id),
    .raddr(start_of(d, k)), .rdata(tag_rdata)
  );

  // size rounding of an incoming request
  logic [15:0]        req_m1;
  logic [4:0]         need_log;
  logic [ID_BITS+15:0] id_ext;
  always_comb begin
    req_m1   = (req.size_kb == 16'd0) ? 16'd0 : req.size_kb - 16'd1;
    need_log = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (req_m1[i]) need_log = 5'(i + 1);
    end
    id_ext = {{ID_BITS{1'b0}}, req.proc_id};
  end

  // scan position helpers
  logic          last_k;
  logic [LW-1:0] cur_start;
  logic          hit;
  always_comb begin
    last_k    = (k == kmax_of(d));
    cur_start = start_of(d, k);
    hit       = (ns_rdata == NS_ALLOC) && (tag_rdata == id) &&
                (!found || (cur_start < best_start));
  end

  // memory port control
  always_comb begin
    ns_we    = 1'b0;
    ns_waddr = node_of(d, k);
    ns_wdata = NS_ABSENT;
    ns_raddr = node_of(d, k);
    tag_we   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ns_we    = 1'b1;
        ns_waddr = clr;
        ns_wdata = (clr == '0) ? NS_FREE : NS_ABSENT;
      end
      S_SP0: begin
        ns_we    = 1'b1;
        ns_wdata = NS_SPLIT;
      end
      S_SP1: begin
        ns_we    = 1'b1;
        ns_waddr = node_of(d + DW'(1), {k[LW-2+1-1:0], 1'b0});
        ns_wdata = NS_FREE;
      end
      S_SP2: begin
        ns_we    = 1'b1;
        ns_waddr = node_of(d + DW'(1), {k[LW-2+1-1:0], 1'b1});
        ns_wdata = NS_FREE;
      end
      S_MARK: begin
        ns_we    = 1'b1;
        ns_wdata = NS_ALLOC;
        tag_we   = 1'b1;
      end
      S_F_SET: begin
        ns_we    = 1'b1;
        ns_waddr = node_of(best_d, best_k);
        ns_wdata = NS_FREE;
      end
      S_M_RD: begin
        ns_raddr = node_of(d, k ^ LW'(1));
      end
      S_M_W0: begin
        ns_we    = 1'b1;
        ns_wdata = NS_ABSENT;
      end
      S_M_W1: begin
        ns_we    = 1'b1;
        ns_waddr = node_of(d, k ^ LW'(1));
        ns_wdata = NS_ABSENT;
      end
      S_M_W2: begin
        ns_we    = 1'b1;
        ns_waddr = node_of(d - DW'(1), k >> 1);
        ns_wdata = NS_FREE;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr == NW'(NODES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (req_valid) begin
          if (req.req_type == REQ_FREE) state_next = S_F_RD;
          else if (need_log > 5'(LW)) state_next = S_RESP;
          else state_next = S_A_RD;
        end
      end
      S_A_RD:  state_next = S_A_CHK;
      S_A_CHK: begin
        if (ns_rdata == NS_FREE) state_next = (d == lvl) ? S_MARK : S_SP0;
        else if (last_k && d == '0) state_next = S_RESP;
        else state_next = S_A_RD;
      end
      S_SP0:   state_next = S_SP1;
      S_SP1:   state_next = S_SP2;
      S_SP2:   state_next = (d + DW'(1) == lvl) ? S_MARK : S_SP0;
      S_MARK:  state_next = S_RESP;
      S_F_RD:  state_next = S_F_CHK;
      S_F_CHK: begin
        if (last_k && d == DW'(LW)) begin
          state_next = (found || hit) ? S_F_SET : S_RESP;
        end else begin
          state_next = S_F_RD;
        end
      end
      S_F_SET: state_next = S_M_RD;
      S_M_RD:  state_next = (d == '0) ? S_RESP : S_M_CHK;
      S_M_CHK: state_next = (ns_rdata == NS_FREE) ? S_M_W0 : S_RESP;
      S_M_W0:  state_next = S_M_W1;
      S_M_W1:  state_next = S_M_W2;
      S_M_W2:  state_next = S_M_RD;
      S_RESP:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + NW'(1);
      if (state == S_IDLE) found <= 1'b0;
      if (state == S_F_CHK && hit) found <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        id  <= id_ext[ID_BITS-1:0];
        lvl <= DW'(LW) - need_log[DW-1:0];
        k   <= '0;
        if (req.req_type == REQ_FREE) d <= '0;
        else d <= DW'(LW) - need_log[DW-1:0];
        res <= '{status: ST_TOO_LARGE, block_addr: 10'd0, block_size: 11'd0};
      end
      S_A_CHK: begin
        if (ns_rdata != NS_FREE) begin
          if (last_k) begin
            if (d == '0) begin
              res <= '{status: ST_NO_BLOCK, block_addr: 10'd0, block_size: 11'd0};
            end else begin
              d <= d - DW'(1);
              k <= '0;
            end
          end else begin
            k <= k + LW'(1);
          end
        end
      end
      S_SP2: begin
        d <= d + DW'(1);
        k <= k << 1;
      end
      S_MARK: begin
        res.status     <= ST_ALLOCATED;
        res.block_addr <= 10'(32'(start_of(d, k)));
        res.block_size <= 11'(32'(size_of(d)));
      end
      S_F_CHK: begin
        if (hit) begin
          best_d     <= d;
          best_k     <= k;
          best_start <= cur_start;
        end
        if (last_k && d == DW'(LW)) begin
          res <= '{status: ST_NOT_FOUND, block_addr: 10'd0, block_size: 11'd0};
        end else if (last_k) begin
          d <= d + DW'(1);
          k <= '0;
        end else begin
          k <= k + LW'(1);
        end
      end
      S_F_SET: begin
        d              <= best_d;
        k              <= best_k;
        res.status     <= ST_FREED;
        res.block_addr <= 10'(32'(best_start));
        res.block_size <= 11'(32'(size_of(best_d)));
      end
      S_M_W2: begin
        d <= d - DW'(1);
        k <= k >> 1;
      end
      default: begin
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP);

endmodule

// ===== hw/rtl/ba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ba_props
// Port level checks of the buddy allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ba_props (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import ba_pkg::*;

  // only defined status codes leave the block
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_ALLOCATED || m_axis_tuser == ST_FREED ||
                       m_axis_tuser == ST_TOO_LARGE || m_axis_tuser == ST_NO_BLOCK ||
                       m_axis_tuser == ST_NOT_FOUND))
    else $error("undefined status code");

  // failures report a zero block
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_TOO_LARGE || m_axis_tuser == ST_NO_BLOCK ||
                      m_axis_tuser == ST_NOT_FOUND) |-> m_axis_tdata == 24'd0)
    else $error("failure result carries a block");

  // a granted or freed block is a power of two in size
  a_pow2: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_ALLOCATED || m_axis_tuser == ST_FREED)
      |-> $onehot(m_axis_tdata[20:10]))
    else $error("block size not a power of two");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
                                        $stable(m_axis_tuser))
    else $error("stalled word changed");

endmodule

bind buddy_allocator ba_props u_ba_props (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// ===== bench/ba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ba_checker
// Watches both stream channels of the buddy allocator, predicts each result
// from its own copy of the block tree and owner tags, and compares in order.
// ----------------------------------------------------------------------------
module ba_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          errors,
  output int          pending
);
  import ba_pkg::*;

  localparam int UNITS  = TOTAL_UNITS_DEF;
  localparam int NODES  = 2 * UNITS - 1;
  localparam int LEVELS = $clog2(UNITS) + 1;

  logic [1:0]  tree_state [NODES];
  logic [15:0] tag_of     [UNITS];
  res_t        expected_results [$];

  function automatic res_t make_res(logic [2:0] st, int addr, int size);
    res_t r;
    r.status     = st;
    r.block_addr = addr[9:0];
    r.block_size = size[10:0];
    return r;
  endfunction

  // smallest free block that fits, lowest address on a tie, split down
  function automatic res_t grant_block(logic [15:0] id, int req);
    int need, lvl, s, node, d, start;
    bit hit;
    need = 1;
    lvl  = 0;
    s    = UNITS;
    hit  = 0;
    node = 0;
    d    = 0;
    while (need < req) need = need << 1;
    if (need > UNITS) return make_res(ST_TOO_LARGE, 0, 0);
    while (s > need) begin
      s = s >> 1;
      lvl++;
    end
    for (int dd = lvl; dd >= 0 && !hit; dd--) begin
      for (int k = 0; k < (1 << dd) && !hit; k++) begin
        if (tree_state[(1 << dd) - 1 + k] == NS_FREE) begin
          node = (1 << dd) - 1 + k;
          d    = dd;
          hit  = 1;
        end
      end
    end
    if (!hit) return make_res(ST_NO_BLOCK, 0, 0);
    while (d < lvl) begin
      tree_state[node]         = NS_SPLIT;
      tree_state[2 * node + 1] = NS_FREE;
      tree_state[2 * node + 2] = NS_FREE;
      node = 2 * node + 1;
      d++;
    end
    tree_state[node] = NS_ALLOC;
    start = (node - ((1 << d) - 1)) * (UNITS >> d);
    tag_of[start] = id;
    return make_res(ST_ALLOCATED, start, UNITS >> d);
  endfunction

  // release lowest-address block owned by id, then merge buddies upward
  function automatic res_t release_block(logic [15:0] id);
    int best_node, best_start, best_size, start, n, sib;
    bit hit;
    hit = 0;
    best_node = 0;
    best_start = 0;
    best_size = 0;
    for (int d = 0; d < LEVELS; d++) begin
      for (int k = 0; k < (1 << d); k++) begin
        start = k * (UNITS >> d);
        if (tree_state[(1 << d) - 1 + k] == NS_ALLOC && tag_of[start] == id &&
            (!hit || start < best_start)) begin
          hit        = 1;
          best_node  = (1 << d) - 1 + k;
          best_start = start;
          best_size  = UNITS >> d;
        end
      end
    end
    if (!hit) return make_res(ST_NOT_FOUND, 0, 0);
    tree_state[best_node] = NS_FREE;
    n = best_node;
    while (n > 0) begin
      sib = (n % 2 == 1) ? n + 1 : n - 1;
      if (tree_state[sib] != NS_FREE) break;
      tree_state[n]   = NS_ABSENT;
      tree_state[sib] = NS_ABSENT;
      n = (n - 1) / 2;
      tree_state[n] = NS_FREE;
    end
    return make_res(ST_FREED, best_start, best_size);
  endfunction

  assign pending = expected_results.size();

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    res_t exp_r;
    int   sz;
    if (rst) begin
      for (int i = 0; i < NODES; i++) tree_state[i] = NS_ABSENT;
      tree_state[0] = NS_FREE;
      expected_results.delete();
      errors <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sz = s_axis_tdata[31:16];
        if (sz == 0) sz = 1;
        if (s_axis_tuser == REQ_ALLOC)
          expected_results.push_back(grant_block(s_axis_tdata[15:0], sz));
        else
          expected_results.push_back(release_block(s_axis_tdata[15:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %h/%h", m_axis_tuser, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tuser !== exp_r.status ||
              m_axis_tdata[9:0] !== exp_r.block_addr ||
              m_axis_tdata[20:10] !== exp_r.block_size ||
              m_axis_tdata[23:21] !== 3'd0) begin
            if (m_axis_tuser !== exp_r.status)
              $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
            if (m_axis_tdata[9:0] !== exp_r.block_addr)
              $error("block_addr: expected %0d, got %0d", exp_r.block_addr,
                     m_axis_tdata[9:0]);
            if (m_axis_tdata[20:10] !== exp_r.block_size)
              $error("block_size: expected %0d, got %0d", exp_r.block_size,
                     m_axis_tdata[20:10]);
            if (m_axis_tdata[23:21] !== 3'd0)
              $error("pad: expected 0, got %0d", m_axis_tdata[23:21]);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the buddy allocator: directed corner requests,
// then random allocate/free traffic under varying source and sink stalls.
// ----------------------------------------------------------------------------
module tb;
  import ba_pkg::*;

  localparam int QUIET_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 1630;
  localparam int HOLD_LEN = 20000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // proc_id, size_kb
  logic        s_axis_tuser;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // block_addr, block_size, zero pad
  logic [2:0]  m_axis_tuser;   // status
  int          errors;
  int          pending;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          hold_cycles;
  logic        hold_req;
  logic        hold_done;
  int          quiet;

  buddy_allocator uut (.*);

  ba_checker chk (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= 0;
      hold_done     <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= HOLD_LEN;
      hold_done     <= 1'b1;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one request word and wait until it is taken
  task automatic send_req(logic kind, logic [15:0] id, logic [15:0] size);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {size, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    int roll;
    logic [15:0] id, size;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_ALLOC;
    src_idle_pct = 31;
    sink_stall_pct = 55;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: size zero, full pool, too large, unknown id,
    // duplicate ids, pool exhausted, merge back to the root
    send_req(REQ_ALLOC, 16'h0001, 16'd0);
    send_req(REQ_ALLOC, 16'h0002, 16'd1);
    send_req(REQ_ALLOC, 16'h0003, 16'd1024);
    send_req(REQ_ALLOC, 16'h0004, 16'd1025);
    send_req(REQ_ALLOC, 16'hFFFF, 16'hFFFF);
    send_req(REQ_ALLOC, 16'hAAAA, 16'h5555);
    send_req(REQ_ALLOC, 16'h5555, 16'hAAAA);
    send_req(REQ_FREE,  16'h7777, 16'hFFFF);
    send_req(REQ_ALLOC, 16'h0001, 16'd3);
    send_req(REQ_FREE,  16'h0001, 16'd0);
    send_req(REQ_FREE,  16'h0001, 16'd0);
    send_req(REQ_FREE,  16'h0002, 16'd0);
    send_req(REQ_ALLOC, 16'hFFFF, 16'd1024);
    send_req(REQ_ALLOC, 16'h0005, 16'd1);
    send_req(REQ_FREE,  16'hFFFF, 16'd0);
    send_req(REQ_ALLOC, 16'h000A, 16'd512);
    send_req(REQ_ALLOC, 16'h000B, 16'd300);
    send_req(REQ_FREE,  16'h000B, 16'd0);
    send_req(REQ_FREE,  16'h000A, 16'd0);
    send_req(REQ_FREE,  16'h0000, 16'd0);

    // random traffic over a small id pool so frees mostly hit
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        src_idle_pct = 55;
        sink_stall_pct = 31;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_req <= 1'b1;
      end
      id = ($urandom_range(99) < 5) ? 16'($urandom) : 16'($urandom_range(31));
      roll = $urandom_range(99);
      if (roll < 70) size = 16'($urandom_range(16));
      else if (roll < 90) size = 16'($urandom_range(256));
      else if (roll < 97) size = 16'($urandom_range(1024));
      else size = 16'($urandom);
      if ($urandom_range(99) < 45) send_req(REQ_FREE, id, 16'($urandom));
      else send_req(REQ_ALLOC, id, size);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    // drain, then a short tail
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== buddy_allocator.f =====
hw/rtl/ba_pkg.sv
hw/rtl/ba_ram.sv
hw/rtl/ba_ctrl.sv
hw/rtl/buddy_allocator.sv
hw/rtl/ba_checker.sv
bench/ba_checker.sv
bench/tb.sv
